// ----- design/beqc_pkg.sv -----
// shared types, constants and the window classifier of the bit-quad euler counter
package beqc_pkg;

  // pixel, register and result widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned REG_W      = 8;
  localparam int unsigned REG_IDX_W  = 2;
  localparam int unsigned CNT_W      = 17;
  localparam int unsigned SUM_W      = 19;
  localparam int unsigned EUL_W      = 17;
  localparam int unsigned INC_W      = 3;
  localparam int unsigned QUAD_NUM   = 6;
  localparam int unsigned OUT_BITS   = QUAD_NUM * CNT_W + SUM_W + EUL_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // counter slots
  localparam int unsigned Q_EMPTY = 0;
  localparam int unsigned Q_ONE   = 1;
  localparam int unsigned Q_ADJ   = 2;
  localparam int unsigned Q_THREE = 3;
  localparam int unsigned Q_FULL  = 4;
  localparam int unsigned Q_DIAG  = 5;

  // configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_TOP    = 2'd0,
    REG_LEFT   = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_WIDTH  = 2'd3
  } reg_idx_e;

  // bounding box registers
  typedef struct packed {
    logic [REG_W-1:0] top;
    logic [REG_W-1:0] left;
    logic [REG_W-1:0] height;
    logic [REG_W-1:0] width;
  } beqc_region_t;

  // per-pixel window increments handed to the counter stage
  typedef struct packed {
    logic                           valid;
    logic                           frame_end;
    logic [QUAD_NUM-1:0][INC_W-1:0] inc;
  } beqc_quad_t;

  // one-hot class of a 2x2 window, a b on top, c d below, 1 means black
  function automatic logic [QUAD_NUM-1:0] quad_class(input logic a, input logic b,
                                                     input logic c, input logic d);
    logic [2:0]          n;
    logic [QUAD_NUM-1:0] hot;
    n   = 3'(a) + 3'(b) + 3'(c) + 3'(d);
    hot = '0;
    unique case (n)
      3'd0: hot[Q_EMPTY] = 1'b1;
      3'd1: hot[Q_ONE]   = 1'b1;
      3'd2: begin
        if ((a & d) | (b & c)) hot[Q_DIAG] = 1'b1;
        else hot[Q_ADJ] = 1'b1;
      end
      3'd3: hot[Q_THREE] = 1'b1;
      default: hot[Q_FULL] = 1'b1;
    endcase
    return hot;
  endfunction

endpackage

// ----- design/beqc_result.sv -----
// quad counters, frame-end snapshot, euler arithmetic and result register
module beqc_result import beqc_pkg::*; #(
  parameter int unsigned FRAME_WIDTH = 256,
  parameter int unsigned FRAME_ROWS  = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  beqc_quad_t            quad_i,
  input  beqc_region_t          region_i,
  output logic                  take_o,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  // count_empty, count_one, count_adjacent_two, count_three, count_full,
  // count_diagonal, euler_sum, euler_number, zero fill
  output logic [OUT_DATA_W-1:0] m_tdata_o
);

  localparam int unsigned EXT_W  = 14;
  localparam int unsigned SPAN_W = 9;
  localparam int unsigned AREA_W = 18;
  localparam int unsigned Q0_W   = 19;
  localparam int unsigned SW_W   = 20;

  localparam logic [EXT_W-1:0] ROWS_LIM = EXT_W'(FRAME_ROWS);
  localparam logic [EXT_W-1:0] COLS_LIM = EXT_W'(FRAME_WIDTH);

  localparam logic signed [SW_W-1:0] SUM_HI = SW_W'((1 << (SUM_W - 1)) - 1);
  localparam logic signed [SW_W-1:0] SUM_LO = -SW_W'(1 << (SUM_W - 1));

  // windows of the widened box that touch the frame along one axis
  function automatic logic [SPAN_W-1:0] touching(input logic [REG_W-1:0] first,
                                                 input logic [REG_W-1:0] span,
                                                 input logic [EXT_W-1:0] limit);
    logic [EXT_W-1:0] lo;
    logic [EXT_W-1:0] hi;
    lo = EXT_W'(first);
    hi = EXT_W'(first) + EXT_W'(span) + EXT_W'(2);
    if (hi > limit) hi = limit;
    return (hi >= lo) ? SPAN_W'(hi - lo + EXT_W'(1)) : '0;
  endfunction

  logic [QUAD_NUM-1:0][CNT_W-1:0] cnt_q, cnt_d;
  logic [QUAD_NUM-1:0][CNT_W-1:0] fin_q;
  logic                           fin_valid_q, fin_valid_d;
  logic                           out_valid_q, out_valid_d;
  logic [OUT_BITS-1:0]            out_data_q;
  logic [AREA_W-1:0]              box_area_q, in_area_q;
  logic                           end_b, fin_move;

  assign end_b    = quad_i.valid && quad_i.frame_end;
  assign fin_move = fin_valid_q && (!out_valid_q || m_tready_i);

  // a frame end may enter only when it can always move on into the snapshot
  assign take_o = !(fin_valid_q && out_valid_q) && !(end_b && (fin_valid_q || out_valid_q));

  // box areas from the registers, recomputed every cycle
  always_ff @(posedge clk_i) begin
    box_area_q <= (AREA_W'(region_i.height) + AREA_W'(3))
                  * (AREA_W'(region_i.width) + AREA_W'(3));
    in_area_q  <= AREA_W'(touching(region_i.top, region_i.height, ROWS_LIM))
                  * AREA_W'(touching(region_i.left, region_i.width, COLS_LIM));
  end

  // saturating counter update
  always_comb begin
    logic [CNT_W:0] s;
    for (int k = 0; k < QUAD_NUM; k++) begin
      s = {1'b0, cnt_q[k]} + (CNT_W + 1)'(quad_i.valid ? quad_i.inc[k] : INC_W'(0));
      cnt_d[k] = s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (end_b) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // snapshot of the finished counts
  always_ff @(posedge clk_i) begin
    if (end_b) fin_q <= cnt_d;
  end

  // result token flow
  always_comb begin
    fin_valid_d = fin_valid_q;
    if (end_b) fin_valid_d = 1'b1;
    else if (fin_move) fin_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (fin_move) out_valid_d = 1'b1;
    else if (m_tready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fin_valid_q <= fin_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // empty count with outside windows, euler sum and number
  always_ff @(posedge clk_i) begin
    logic [Q0_W-1:0]        q0w;
    logic [CNT_W-1:0]       q0;
    logic signed [SW_W-1:0] sw;
    logic signed [SW_W-1:0] sc;
    if (fin_move) begin
      q0w = Q0_W'(fin_q[Q_EMPTY]) + Q0_W'(box_area_q) - Q0_W'(in_area_q);
      q0  = (q0w > Q0_W'(CNT_MAX)) ? CNT_MAX : q0w[CNT_W-1:0];
      sw  = $signed(SW_W'(fin_q[Q_ONE])) - $signed(SW_W'(fin_q[Q_THREE]))
            - $signed(SW_W'({fin_q[Q_DIAG], 1'b0}));
      if (sw > SUM_HI) sc = SUM_HI;
      else if (sw < SUM_LO) sc = SUM_LO;
      else sc = sw;
      out_data_q <= {sc[SUM_W-1:2], sc[SUM_W-1:0], fin_q[Q_DIAG], fin_q[Q_FULL],
                     fin_q[Q_THREE], fin_q[Q_ADJ], fin_q[Q_ONE], q0};
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {(OUT_DATA_W - OUT_BITS)'(0), out_data_q};

  // a frame end in the counter stage never finds the snapshot blocked
  a_no_token_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_b |-> (!fin_valid_q || fin_move))
    else $error("frame end arrived while snapshot was blocked");

  // counters restart from zero after a frame end
  a_counters_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_b |=> (cnt_q == '0))
    else $error("counters not cleared after frame end");

endmodule

// ----- design/bit_quad_euler_counter.sv -----
// top level of the bit-quad euler counter: line buffer, window classifier, config
// Takes one pixel per clock while input ready is high: the one-bit line buffer is read
// ahead at the next column while the current column is written, so each pixel needs
// a single read and a single write of that memory. The tally of a frame moves from
// the counter stage into the snapshot and then into the output register, which it
// enters once that register is free. Input ready drops when a frame end reaches the
// counter stage while an earlier result is still on its way out, and stays low for
// as long as one result waits at the output and another waits behind it. The line
// buffer needs no clearing after reset; rows never read stale contents.
// Configuration must be written only while the block is idle, which the block does
// not enforce itself; a write takes effect for the next pixel.
module bit_quad_euler_counter import beqc_pkg::*; #(
  parameter int unsigned FRAME_WIDTH = 256,
  parameter int unsigned FRAME_ROWS  = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [REG_W-1:0]      cfg_data_i,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  // pixel_value
  input  logic [PIX_W-1:0]      s_tdata_i,
  input  logic                  s_tlast_i,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  // count_empty, count_one, count_adjacent_two, count_three, count_full,
  // count_diagonal, euler_sum, euler_number, zero fill
  output logic [OUT_DATA_W-1:0] m_tdata_o
);

  localparam int unsigned CW    = $clog2(FRAME_WIDTH);
  localparam int unsigned RW    = $clog2(FRAME_ROWS);
  localparam int unsigned MAX_W = (RW > CW) ? RW : CW;
  localparam int unsigned CMP_W = ((MAX_W > 10) ? MAX_W : 10) + 1;

  localparam logic [CW-1:0] COL_LAST = CW'(FRAME_WIDTH - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(FRAME_ROWS - 1);

  beqc_region_t     region_q;
  beqc_quad_t       quad_q, quad_d;
  logic             row_mem_q [FRAME_WIDTH];
  logic             up_raw_q;
  logic [CW-1:0]    col_q, col_d;
  logic [RW-1:0]    row_q, row_d;
  logic             left_q, left_d;
  logic             ul_q, ul_d;
  logic             take, accept;
  logic             cur, up, ul, lf;
  logic             last_col, last_row;
  logic             row_a, row_b, col_a, col_b;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_TOP:    region_q.top    <= cfg_data_i;
        REG_LEFT:   region_q.left   <= cfg_data_i;
        REG_HEIGHT: region_q.height <= cfg_data_i;
        REG_WIDTH:  region_q.width  <= cfg_data_i;
      endcase
    end
  end

  assign s_tready_o = take;
  assign accept     = s_tvalid_i && take;

  // current pixel and its neighbours, white outside the frame
  assign cur      = (s_tdata_i == '0);
  assign up       = (row_q != '0) ? up_raw_q : 1'b0;
  assign ul       = (row_q != '0 && col_q != '0) ? ul_q : 1'b0;
  assign lf       = (col_q != '0) ? left_q : 1'b0;
  assign last_col = (col_q == COL_LAST);
  assign last_row = (row_q == ROW_LAST);

  // box membership of the windows ending at this pixel
  always_comb begin
    logic [CMP_W-1:0] r0, r1, c0, c1, r_hi, c_hi, t, l;
    r0    = CMP_W'(row_q);
    r1    = r0 + CMP_W'(1);
    c0    = CMP_W'(col_q);
    c1    = c0 + CMP_W'(1);
    t     = CMP_W'(region_q.top);
    l     = CMP_W'(region_q.left);
    r_hi  = t + CMP_W'(region_q.height) + CMP_W'(2);
    c_hi  = l + CMP_W'(region_q.width) + CMP_W'(2);
    row_a = (r0 >= t) && (r0 <= r_hi);
    row_b = (r1 >= t) && (r1 <= r_hi);
    col_a = (c0 >= l) && (c0 <= c_hi);
    col_b = (c1 >= l) && (c1 <= c_hi);
  end

  // classify up to four windows and sum their increments per class
  always_comb begin
    logic [QUAD_NUM-1:0] w0, w1, w2, w3;
    w0 = quad_class(ul, up, lf, cur) & {QUAD_NUM{row_a && col_a}};
    w1 = quad_class(up, 1'b0, cur, 1'b0) & {QUAD_NUM{last_col && row_a && col_b}};
    w2 = quad_class(lf, cur, 1'b0, 1'b0) & {QUAD_NUM{last_row && row_b && col_a}};
    w3 = quad_class(cur, 1'b0, 1'b0, 1'b0)
         & {QUAD_NUM{last_col && last_row && row_b && col_b}};
    quad_d.valid     = accept;
    quad_d.frame_end = s_tlast_i;
    for (int k = 0; k < QUAD_NUM; k++) begin
      quad_d.inc[k] = INC_W'(w0[k]) + INC_W'(w1[k]) + INC_W'(w2[k]) + INC_W'(w3[k]);
    end
  end

  // scan position and neighbour pixels
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    left_d = left_q;
    ul_d   = ul_q;
    if (accept) begin
      if (s_tlast_i) begin
        col_d  = '0;
        row_d  = '0;
        left_d = 1'b0;
        ul_d   = 1'b0;
      end else begin
        left_d = cur;
        ul_d   = up;
        if (last_col) begin
          col_d = '0;
          row_d = last_row ? '0 : row_q + RW'(1);
        end else begin
          col_d = col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= 1'b0;
      ul_q   <= 1'b0;
      quad_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      left_q <= left_d;
      ul_q   <= ul_d;
      quad_q <= quad_d;
    end
  end

  // line buffer: write this column, read the next one ahead
  always_ff @(posedge clk_i) begin
    if (accept) row_mem_q[col_q] <= cur;
    up_raw_q <= row_mem_q[col_d];
  end

  beqc_result #(
    .FRAME_WIDTH(FRAME_WIDTH),
    .FRAME_ROWS (FRAME_ROWS)
  ) u_result (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .quad_i    (quad_q),
    .region_i  (region_q),
    .take_o    (take),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o)
  );

  // scan position stays inside the frame
  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= COL_LAST) && (row_q <= ROW_LAST))
    else $error("scan position left the frame");

  // a frame end restarts the scan at the top-left corner
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_tlast_i) |=> (col_q == '0 && row_q == '0 && !left_q && !ul_q))
    else $error("scan not restarted after frame end");

endmodule

// ----- dv/bit_quad_euler_counter_tb.sv -----
// self-checking testbench of the bit-quad euler counter: predicts window tallies per frame
module bit_quad_euler_counter_tb;
  import beqc_pkg::*;

  localparam int unsigned FRAME_W       = 256;
  localparam int unsigned FRAME_H       = 256;
  localparam int          CLK_HALF      = 6;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          LONG_HOLD     = 300;
  localparam longint      RUN_LIMIT     = 64'd4_000_000 * 2 * CLK_HALF;
  localparam longint      SUM_HI        = 262143;
  localparam longint      SUM_LO        = -262144;

  // one pixel request as offered on the input stream
  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             last;
  } pixel_req_t;

  // result layout of m_tdata_o, lowest field in the lowest bits
  typedef struct packed {
    logic [OUT_DATA_W-OUT_BITS-1:0]  fill;
    logic [EUL_W-1:0]                euler_number;
    logic [SUM_W-1:0]                euler_sum;
    logic [QUAD_NUM-1:0][CNT_W-1:0]  counts;
  } quad_result_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_e;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_idx_i  = REG_TOP;
  logic [REG_W-1:0]      cfg_data_i = '0;
  logic                  s_tvalid_i = 1'b0;
  logic                  s_tready_o;
  logic [PIX_W-1:0]      s_tdata_i  = '0;
  logic                  s_tlast_i  = 1'b0;
  logic                  m_tvalid_o;
  logic                  m_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata_o;

  // stimulus and expectation stores
  pixel_req_t   pixel_q[$];
  quad_result_t frame_tally_q[$];
  int           mismatch_count = 0;
  logic         long_hold_req  = 1'b0;

  // predictor state and register shadow
  logic [REG_W-1:0] box_top, box_left, box_height, box_width;
  bit               prev_row [FRAME_W];
  bit               left_px, upper_left_px;
  int               scan_row, scan_col;
  int unsigned      tallies [QUAD_NUM];

  // sender and receiver pacing
  int       burst_left = 0;
  int       gap_left   = 0;
  int       hold_left  = 0;
  int       mode_left  = 0;
  rx_mode_e rx_mode    = RX_ALWAYS;
  logic [7:0] rx_tick  = '0;

  string tally_names [QUAD_NUM] = '{"count_empty", "count_one", "count_adjacent_two",
                                    "count_three", "count_full", "count_diagonal"};

  // directed frames: single black pixel, short mixed frames, a black run
  logic [PIX_W-1:0] probe_pix [20] = '{8'h00,
                                       8'h00, 8'h00, 8'hFF, 8'h01,
                                       8'h80, 8'h00, 8'h7F, 8'h00, 8'hFE, 8'h00, 8'h00,
                                       8'h55, 8'hAA,
                                       8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [19:0] PROBE_LAST = 20'h82011;

  bit_quad_euler_counter #(
    .FRAME_WIDTH (FRAME_W),
    .FRAME_ROWS  (FRAME_H)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  // clock
  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // rows of the box widened by one that fall inside the frame
  function automatic int span_in_frame(int first, int size, int limit);
    int lo, hi;
    lo = first - 1;
    hi = first + size + 1;
    if (hi > limit - 1) hi = limit - 1;
    return (hi >= lo) ? hi - lo + 1 : 0;
  endfunction

  // classify one 2x2 window with top-left corner (i,j) if it lies in the widened box
  function automatic void tally_window(int i, int j, bit a, bit b, bit c, bit d);
    int n, slot;
    if (i < int'(box_top) - 1 || i > int'(box_top) + int'(box_height) + 1) return;
    if (j < int'(box_left) - 1 || j > int'(box_left) + int'(box_width) + 1) return;
    n = int'(a) + int'(b) + int'(c) + int'(d);
    unique case (n)
      0: slot = Q_EMPTY;
      1: slot = Q_ONE;
      2: slot = ((a & d) | (b & c)) ? Q_DIAG : Q_ADJ;
      3: slot = Q_THREE;
      default: slot = Q_FULL;
    endcase
    if (tallies[slot] < CNT_MAX) tallies[slot]++;
  endfunction

  // clear scan position and tallies, as after reset or a frame end
  function automatic void restart_scan();
    scan_row      = 0;
    scan_col      = 0;
    left_px       = 1'b0;
    upper_left_px = 1'b0;
    foreach (tallies[k]) tallies[k] = 0;
  endfunction

  // advance the raster scan by one accepted pixel, queue the frame result on its end
  function automatic void scan_pixel(logic [PIX_W-1:0] value, logic last);
    bit           cur, up, ul, lf, end_col, end_row;
    int           r, c;
    longint       in_frame, q0, sum, eul;
    quad_result_t res;
    cur     = (value == '0);
    r       = scan_row;
    c       = scan_col;
    up      = (r > 0) ? prev_row[c] : 1'b0;
    ul      = (r > 0 && c > 0) ? upper_left_px : 1'b0;
    lf      = (c > 0) ? left_px : 1'b0;
    end_col = (c == FRAME_W - 1);
    end_row = (r == FRAME_H - 1);

    // windows this pixel completes, more of them at the right and bottom edges
    tally_window(r - 1, c - 1, ul, up, lf, cur);
    if (end_col) tally_window(r - 1, c, up, 1'b0, cur, 1'b0);
    if (end_row) tally_window(r, c - 1, lf, cur, 1'b0, 1'b0);
    if (end_col && end_row) tally_window(r, c, cur, 1'b0, 1'b0, 1'b0);

    prev_row[c]   = cur;
    upper_left_px = up;
    left_px       = cur;
    if (end_col) begin
      scan_col = 0;
      scan_row = end_row ? 0 : r + 1;
    end else begin
      scan_col = c + 1;
    end

    if (!last) return;

    // windows of the box off the frame are all white and go to the empty count
    in_frame = longint'(span_in_frame(box_top, box_height, FRAME_H))
             * span_in_frame(box_left, box_width, FRAME_W);
    q0 = longint'(tallies[Q_EMPTY])
       + (longint'(box_height) + 3) * (longint'(box_width) + 3) - in_frame;
    if (q0 > longint'(CNT_MAX)) q0 = CNT_MAX;
    res = '0;
    res.counts[Q_EMPTY] = q0[CNT_W-1:0];
    for (int k = Q_ONE; k <= Q_DIAG; k++) res.counts[k] = CNT_W'(tallies[k]);
    sum = longint'(tallies[Q_ONE]) - longint'(tallies[Q_THREE])
        - 2 * longint'(tallies[Q_DIAG]);
    if (sum > SUM_HI) sum = SUM_HI;
    if (sum < SUM_LO) sum = SUM_LO;
    eul = sum >>> 2;
    res.euler_sum    = sum[SUM_W-1:0];
    res.euler_number = eul[EUL_W-1:0];
    frame_tally_q.push_back(res);
    restart_scan();
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch in %s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // sender: bursts of random length with random gaps, holds a request until taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
      s_tdata_i  <= '0;
      s_tlast_i  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!s_tvalid_i || s_tready_o) begin
      if (burst_left == 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (burst_left > 0 && pixel_q.size() > 0) begin
        s_tvalid_i <= 1'b1;
        s_tdata_i  <= pixel_q[0].value;
        s_tlast_i  <= pixel_q[0].last;
        void'(pixel_q.pop_front());
        burst_left--;
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver: stall pattern that changes mode, plus one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
      hold_left  = 0;
      mode_left  = 0;
    end else begin
      rx_tick <= rx_tick + 8'd1;
      if (long_hold_req) hold_left = LONG_HOLD;
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 128);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_tready_i <= 1'b0;
      end else begin
        unique case (rx_mode)
          RX_ALWAYS:   m_tready_i <= 1'b1;
          RX_COIN:     m_tready_i <= 1'($urandom_range(0, 1));
          RX_PERIODIC: m_tready_i <= (rx_tick[2:0] != 3'd0);
          default:     m_tready_i <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // input monitor: every accepted pixel goes through the predictor
  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid_i && s_tready_o) scan_pixel(s_tdata_i, s_tlast_i);
  end

  // output monitor: compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    quad_result_t got, want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got = m_tdata_o;
      if (frame_tally_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("result with no frame end pending: %h", got);
      end else begin
        want = frame_tally_q.pop_front();
        for (int k = 0; k < QUAD_NUM; k++)
          check_field(tally_names[k], want.counts[k], got.counts[k]);
        check_field("euler_sum", $signed(want.euler_sum), $signed(got.euler_sum));
        check_field("euler_number", $signed(want.euler_number), $signed(got.euler_number));
        check_field("zero fill", want.fill, got.fill);
      end
    end
  end

  // write all four box registers, only while the block is idle
  task automatic load_region(input logic [REG_W-1:0] top, input logic [REG_W-1:0] left,
                             input logic [REG_W-1:0] height, input logic [REG_W-1:0] width);
    reg_idx_e         order [4];
    logic [REG_W-1:0] vals  [4];
    order = '{REG_TOP, REG_LEFT, REG_HEIGHT, REG_WIDTH};
    vals  = '{top, left, height, width};
    for (int k = 0; k < 4; k++) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= order[k];
      cfg_data_i <= vals[k];
    end
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    box_top    = top;
    box_left   = left;
    box_height = height;
    box_width  = width;
  endtask

  // wait until every request is taken and every frame result has come back
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pixel_q.size() != 0 || s_tvalid_i || frame_tally_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [PIX_W-1:0] draw_pixel(int black_pct);
    if ($urandom_range(0, 99) < black_pct) return '0;
    return PIX_W'($urandom_range(1, 255));
  endfunction

  function automatic void queue_frame(int len, int black_pct);
    pixel_req_t req;
    for (int k = 0; k < len; k++) begin
      req.value = draw_pixel(black_pct);
      req.last  = (k == len - 1);
      pixel_q.push_back(req);
    end
  endfunction

  // random frames, mostly short, a few crossing into the next row
  task automatic run_frames(int item_goal, int frame_goal);
    int items, frames, len, sel;
    items  = 0;
    frames = 0;
    while (items < item_goal || frames < frame_goal) begin
      sel = $urandom_range(0, 99);
      if (sel < 80)      len = $urandom_range(1, 16);
      else if (sel < 95) len = $urandom_range(17, 120);
      else               len = $urandom_range(FRAME_W + 1, FRAME_W + 40);
      queue_frame(len, $urandom_range(0, 4) * 25);
      items  += len;
      frames++;
    end
  endtask

  // main sequence
  initial begin : stimulus
    pixel_req_t req;
    restart_scan();
    foreach (prev_row[k]) prev_row[k] = 1'b0;
    box_top    = '0;
    box_left   = '0;
    box_height = '0;
    box_width  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed frames with the smallest box at the top-left corner
    load_region(8'd0, 8'd0, 8'd0, 8'd0);
    for (int k = 0; k < 20; k++) begin
      req.value = probe_pix[k];
      req.last  = PROBE_LAST[k];
      pixel_q.push_back(req);
    end

    // random frames over a range of boxes, extremes first
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      unique case (p)
        0: load_region(8'd255, 8'd255, 8'd255, 8'd255);
        1: load_region(8'd0, 8'd0, 8'd255, 8'd255);
        2: load_region(8'd0, 8'd255, 8'd1, 8'd0);
        3: load_region(8'd1, 8'd250, 8'd0, 8'd3);
        default: begin
          if ($urandom_range(0, 3) == 0)
            load_region(REG_W'($urandom_range(0, 255)), REG_W'($urandom_range(0, 255)),
                        REG_W'($urandom_range(0, 255)), REG_W'($urandom_range(0, 255)));
          else
            load_region(REG_W'($urandom_range(0, 2)), REG_W'($urandom_range(0, 255)),
                        REG_W'($urandom_range(0, 3)), REG_W'($urandom_range(0, 255)));
        end
      endcase
      // one frame past the right edge into the second row with the whole box
      if (p == 1) queue_frame(FRAME_W + 8, 25);
      run_frames(40, 3);
    end

    // back-to-back frame ends while the receiver holds off
    wait_idle();
    load_region(REG_W'($urandom_range(0, 2)), REG_W'($urandom_range(0, 8)),
                REG_W'($urandom_range(0, 2)), REG_W'($urandom_range(0, 8)));
    long_hold_req <= 1'b1;
    @(posedge clk_i);
    long_hold_req <= 1'b0;
    for (int k = 0; k < 40; k++) queue_frame($urandom_range(1, 2), 50);

    wait_idle();
    if (frame_tally_q.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
design/beqc_pkg.sv
design/beqc_result.sv
design/bit_quad_euler_counter.sv
dv/bit_quad_euler_counter_tb.sv
